>>> sv/fdl_pkg.sv
`timescale 1ns / 1ps

package fdl_pkg;

  // Delay store geometry
  localparam int STORE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SUM_W       = ADDR_W + 1;
  localparam int FILL_W      = $clog2(STORE_DEPTH + 1);

  // Field widths
  localparam int DATA_W    = 32;
  localparam int STEP_W    = 8;
  localparam int FRAC_W    = 16;
  localparam int TAP_W     = 8;
  localparam int ACT_W     = 2;
  localparam int CFG_IDX_W = 2;

  // Blend arithmetic: base + ((w * diff) >>> FRAC_W)
  localparam int DIFF_W = DATA_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_W + 1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CRED_W      = QCNT_W + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_UPDATE     = 2'd0,
    ACT_READ_DELAY = 2'd1,
    ACT_READ_TAP   = 2'd2,
    ACT_RESTART    = 2'd3
  } act_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_DELAY  = 2'd0,
    CFG_FRAC_WEIGHT = 2'd1,
    CFG_INIT_VALUE  = 2'd2
  } cfg_e;

  // One resolved read, waiting for the blend
  typedef struct packed {
    logic signed [DATA_W-1:0] base;
    logic signed [DIFF_W-1:0] diff;
    logic                     err;
  } queue_word_t;

endpackage

>>> sv/fdl_in_if.sv
`timescale 1ns / 1ps

interface fdl_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [fdl_pkg::ACT_W-1:0]            action;
  logic                                 use_held;
  logic                                 new_step;
  logic signed [fdl_pkg::DATA_W-1:0]    sample;
  logic [fdl_pkg::TAP_W-1:0]            tap_index;

  modport source (output valid, action, use_held, new_step, sample, tap_index,
                  input ready);
  modport sink (input valid, action, use_held, new_step, sample, tap_index,
                output ready);
endinterface

>>> sv/fdl_out_if.sv
`timescale 1ns / 1ps

interface fdl_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [fdl_pkg::DATA_W-1:0] result_value;
  logic                              index_error;

  modport source (output valid, result_value, index_error, input ready);
  modport sink (input valid, result_value, index_error, output ready);
endinterface

>>> sv/fdl_ram.sv
`timescale 1ns / 1ps

module fdl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port (old data on collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/fdl_front.sv
`timescale 1ns / 1ps

module fdl_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  fdl_in_if.sink                            in_i,
  input  logic [fdl_pkg::STEP_W-1:0]        step_delay_i,
  input  logic                              blend_en_i,
  input  logic signed [fdl_pkg::DATA_W-1:0] init_value_i,
  input  logic [fdl_pkg::QCNT_W-1:0]        q_count_i,
  output logic                              push_o,
  output fdl_pkg::queue_word_t              word_o
);

  // Position k steps back from head h, modulo the store depth
  function automatic logic [fdl_pkg::ADDR_W-1:0] addr_back(
    input logic [fdl_pkg::ADDR_W-1:0] h,
    input logic [fdl_pkg::ADDR_W-1:0] k
  );
    logic [fdl_pkg::SUM_W-1:0] t;
    t = fdl_pkg::SUM_W'(h) + fdl_pkg::SUM_W'(fdl_pkg::STORE_DEPTH) - fdl_pkg::SUM_W'(k);
    if (t >= fdl_pkg::SUM_W'(fdl_pkg::STORE_DEPTH)) begin
      t = t - fdl_pkg::SUM_W'(fdl_pkg::STORE_DEPTH);
    end
    return t[fdl_pkg::ADDR_W-1:0];
  endfunction

  // Line pointers
  logic [fdl_pkg::ADDR_W-1:0] head_q, head_d;
  logic [fdl_pkg::FILL_W-1:0] fill_q, fill_d;
  logic signed [fdl_pkg::DATA_W-1:0] newest_q;

  // Read stage: descriptor that lines up with the registered store data
  logic                              s1_v_q, s1_v_d;
  logic                              s1_err_q, s1_blend_q;
  logic                              s1_ok_a_q, s1_ok_b_q;
  logic                              s1_byp_a_q, s1_byp_b_q;
  logic signed [fdl_pkg::DATA_W-1:0] s1_wval_q;

  logic                              accept;
  fdl_pkg::act_e                     act;
  logic                              do_write, want_read, is_tap, restart;
  logic                              push_step;
  logic [fdl_pkg::ADDR_W-1:0]        head_inc, head_new;
  logic [fdl_pkg::FILL_W-1:0]        fill_new;
  logic signed [fdl_pkg::DATA_W-1:0] wval;
  logic [fdl_pkg::ADDR_W-1:0]        dly, k_a, k_b;
  logic                              tap_err;
  logic [fdl_pkg::ADDR_W-1:0]        raddr_a, raddr_b;
  logic [fdl_pkg::DATA_W-1:0]        rdata_a, rdata_b;
  logic signed [fdl_pkg::DATA_W-1:0] xa, xb;

  // Room for this word and the one in the read stage
  assign in_i.ready = (fdl_pkg::CRED_W'(q_count_i) + fdl_pkg::CRED_W'(s1_v_q))
                      < fdl_pkg::CRED_W'(fdl_pkg::QUEUE_DEPTH);
  assign accept = in_i.valid && in_i.ready;
  assign act    = fdl_pkg::act_e'(in_i.action);

  // Action decode
  always_comb begin
    do_write  = 1'b0;
    want_read = 1'b0;
    is_tap    = 1'b0;
    restart   = 1'b0;
    unique case (act)
      fdl_pkg::ACT_UPDATE: begin
        do_write = 1'b1;
      end
      fdl_pkg::ACT_READ_DELAY: begin
        do_write  = 1'b1;
        want_read = 1'b1;
      end
      fdl_pkg::ACT_READ_TAP: begin
        do_write  = 1'b1;
        want_read = 1'b1;
        is_tap    = 1'b1;
      end
      fdl_pkg::ACT_RESTART: begin
        restart = 1'b1;
      end
    endcase
  end

  // Line update: push on a new step or on the first write after restart
  always_comb begin
    push_step = in_i.new_step || (fill_q == '0);
    head_inc  = (head_q == fdl_pkg::ADDR_W'(fdl_pkg::STORE_DEPTH - 1)) ? '0 : head_q + 1'b1;
    head_new  = push_step ? head_inc : head_q;
    fill_new  = (push_step && (fill_q < fdl_pkg::FILL_W'(fdl_pkg::STORE_DEPTH)))
                ? fill_q + 1'b1 : fill_q;
    if (in_i.use_held) begin
      wval = (fill_q != '0) ? newest_q : init_value_i;
    end else begin
      wval = in_i.sample;
    end
  end

  // Read positions, delay saturated to the store
  always_comb begin
    if (32'(step_delay_i) > 32'(fdl_pkg::STORE_DEPTH - 1)) begin
      dly = fdl_pkg::ADDR_W'(fdl_pkg::STORE_DEPTH - 1);
    end else begin
      dly = fdl_pkg::ADDR_W'(step_delay_i);
    end
    tap_err = 32'(in_i.tap_index) > 32'(dly);
    k_a     = is_tap ? fdl_pkg::ADDR_W'(in_i.tap_index) : dly;
    k_b     = dly - 1'b1;
    raddr_a = addr_back(head_new, k_a);
    raddr_b = addr_back(head_new, k_b);
  end

  // Two copies of the store give two reads per cycle
  fdl_ram #(
    .WIDTH (fdl_pkg::DATA_W),
    .DEPTH (fdl_pkg::STORE_DEPTH)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (accept && do_write),
    .waddr_i (head_new),
    .wdata_i (wval),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  fdl_ram #(
    .WIDTH (fdl_pkg::DATA_W),
    .DEPTH (fdl_pkg::STORE_DEPTH)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (accept && do_write),
    .waddr_i (head_new),
    .wdata_i (wval),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // Pointer next state
  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (accept) begin
      if (restart) begin
        head_d = '0;
        fill_d = '0;
      end else begin
        head_d = head_new;
        fill_d = fill_new;
      end
    end
    s1_v_d = accept && want_read;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      s1_v_q <= 1'b0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
      s1_v_q <= s1_v_d;
    end
  end

  // Newest sample and read-stage descriptor
  always_ff @(posedge clk_i) begin
    if (accept && !restart) begin
      newest_q <= wval;
    end
    if (accept) begin
      s1_err_q   <= is_tap && tap_err;
      s1_blend_q <= !is_tap && blend_en_i && (dly != '0);
      s1_ok_a_q  <= fdl_pkg::FILL_W'(k_a) < fill_new;
      s1_ok_b_q  <= fdl_pkg::FILL_W'(k_b) < fill_new;
      s1_byp_a_q <= k_a == '0;
      s1_byp_b_q <= k_b == '0;
      s1_wval_q  <= wval;
    end
  end

  // Resolve: unwritten -> init value, newest -> the value just written
  always_comb begin
    if (!s1_ok_a_q) begin
      xa = init_value_i;
    end else if (s1_byp_a_q) begin
      xa = s1_wval_q;
    end else begin
      xa = $signed(rdata_a);
    end
    if (!s1_ok_b_q) begin
      xb = init_value_i;
    end else if (s1_byp_b_q) begin
      xb = s1_wval_q;
    end else begin
      xb = $signed(rdata_b);
    end
  end

  // Queue word: result = base + ((w * diff) >>> 16)
  always_comb begin
    word_o.err = s1_err_q;
    if (s1_err_q) begin
      word_o.base = '0;
      word_o.diff = '0;
    end else if (s1_blend_q) begin
      word_o.base = xb;
      word_o.diff = {xa[fdl_pkg::DATA_W-1], xa} - {xb[fdl_pkg::DATA_W-1], xb};
    end else begin
      word_o.base = xa;
      word_o.diff = '0;
    end
  end

  assign push_o = s1_v_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= fdl_pkg::FILL_W'(fdl_pkg::STORE_DEPTH))
    else $error("fill count beyond store depth");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && restart) |=> (fill_q == '0 && head_q == '0 && !s1_v_q))
    else $error("restart did not clear the line");
`endif

endmodule

>>> sv/fdl_queue.sv
`timescale 1ns / 1ps

module fdl_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  fdl_pkg::queue_word_t       word_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output fdl_pkg::queue_word_t       word_o,
  output logic [fdl_pkg::QCNT_W-1:0] count_o
);

  fdl_pkg::queue_word_t        mem_q [fdl_pkg::QUEUE_DEPTH];
  logic [fdl_pkg::QPTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [fdl_pkg::QCNT_W-1:0]  count_q, count_d;
  logic                        do_pop;

  assign do_pop = pop_i && (count_q != '0);

  // Pointer and count update
  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push_i) begin
      wr_d = (wr_q == fdl_pkg::QPTR_W'(fdl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == fdl_pkg::QPTR_W'(fdl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= word_i;
    end
  end

  assign valid_o = count_q != '0;
  assign word_o  = mem_q[rd_q];
  assign count_o = count_q;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < fdl_pkg::QCNT_W'(fdl_pkg::QUEUE_DEPTH)) || do_pop)
    else $error("queue written while full");
`endif

endmodule

>>> sv/fdl_back.sv
`timescale 1ns / 1ps

module fdl_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  fdl_pkg::queue_word_t       q_word_i,
  input  logic [fdl_pkg::FRAC_W-1:0] frac_weight_i,
  output logic                       pop_o,
  fdl_out_if.source                  out_o
);

  // Multiply stage
  logic                              a_v_q;
  logic signed [fdl_pkg::PROD_W-1:0] prod_q;
  logic signed [fdl_pkg::DATA_W-1:0] base_q;
  logic                              err_q;

  // Output register
  logic                              out_v_q;
  logic signed [fdl_pkg::DATA_W-1:0] res_q;
  logic                              res_err_q;

  logic                              out_free, a_free;
  logic signed [fdl_pkg::PROD_W-1:0] prod_d;
  logic signed [fdl_pkg::DATA_W-1:0] res_d;

  assign out_free = !out_v_q || out_o.ready;
  assign a_free   = !a_v_q || out_free;
  assign pop_o    = q_valid_i && a_free;

  // Weight times difference, then shift and add to the base
  assign prod_d = q_word_i.diff * $signed({1'b0, frac_weight_i});
  assign res_d  = base_q + prod_q[fdl_pkg::FRAC_W +: fdl_pkg::DATA_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (a_free) begin
        a_v_q <= pop_o;
      end
      if (out_free) begin
        out_v_q <= a_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_q <= prod_d;
      base_q <= q_word_i.base;
      err_q  <= q_word_i.err;
    end
    if (out_free && a_v_q) begin
      res_q     <= res_d;
      res_err_q <= err_q;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.result_value = res_q;
  assign out_o.index_error  = res_err_q;

`ifndef SYNTHESIS
  a_hold_mul_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_v_q && out_v_q && !out_o.ready) |=> a_v_q)
    else $error("multiply stage dropped a word under stall");
`endif

endmodule

>>> sv/fractional_delay_line_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Word fields                                  Handshake
// in_i     in   action, use_held, new_step, sample, tap_index valid/ready
// out_o    out  result_value, index_error                     valid/ready
// cfg      in   cfg_idx_i, cfg_data_i                         cfg_we_i, no wait
//
// One input word per cycle while in_i.ready is high; a read result passes the store read
// register, the queue, the multiply register and the output register before it is valid.
// The store is two copies of a one-write/one-read RAM, so both blend
// operands come out in the same cycle.
// Reset clears the pointers and fill count; no clearing pass is needed.
// Input is held off only when the four-entry queue cannot take another word beyond the one in the read stage.
module fractional_delay_line_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fdl_in_if.sink                        in_i,
  fdl_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [fdl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fdl_pkg::DATA_W-1:0]    cfg_data_i
);

  logic [fdl_pkg::STEP_W-1:0]        step_delay_q, step_delay_d;
  logic [fdl_pkg::FRAC_W-1:0]        frac_weight_q, frac_weight_d;
  logic signed [fdl_pkg::DATA_W-1:0] init_value_q, init_value_d;

  logic                              push, pop, q_valid;
  fdl_pkg::queue_word_t              push_word, q_word;
  logic [fdl_pkg::QCNT_W-1:0]        q_count;

  // Configuration register decode
  always_comb begin
    step_delay_d  = step_delay_q;
    frac_weight_d = frac_weight_q;
    init_value_d  = init_value_q;
    if (cfg_we_i) begin
      unique case (fdl_pkg::cfg_e'(cfg_idx_i))
        fdl_pkg::CFG_STEP_DELAY:  step_delay_d  = cfg_data_i[fdl_pkg::STEP_W-1:0];
        fdl_pkg::CFG_FRAC_WEIGHT: frac_weight_d = cfg_data_i[fdl_pkg::FRAC_W-1:0];
        fdl_pkg::CFG_INIT_VALUE:  init_value_d  = $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_delay_q  <= fdl_pkg::STEP_W'(1);
      frac_weight_q <= '0;
      init_value_q  <= '0;
    end else begin
      step_delay_q  <= step_delay_d;
      frac_weight_q <= frac_weight_d;
      init_value_q  <= init_value_d;
    end
  end

  fdl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .step_delay_i (step_delay_q),
    .blend_en_i   (frac_weight_q != '0),
    .init_value_i (init_value_q),
    .q_count_i    (q_count),
    .push_o       (push),
    .word_o       (push_word)
  );

  fdl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_i  (push_word),
    .pop_i   (pop),
    .valid_o (q_valid),
    .word_o  (q_word),
    .count_o (q_count)
  );

  fdl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_word_i      (q_word),
    .frac_weight_i (frac_weight_q),
    .pop_o         (pop),
    .out_o         (out_o)
  );

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.index_error) |-> (out_o.result_value == '0))
    else $error("tap error word carries a nonzero value");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fdl_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 150;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     err;
  } delay_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DATA_W-1:0]    cfg_data;

  fdl_in_if  in_if ();
  fdl_out_if out_if ();

  fractional_delay_line_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the delay line
  logic signed [DATA_W-1:0] line_mem [STORE_DEPTH];
  logic [ADDR_W-1:0]        newest_pos;
  logic [FILL_W-1:0]        pushed_cnt;
  logic [STEP_W-1:0]        delay_steps;
  logic [FRAC_W-1:0]        blend_w;
  logic signed [DATA_W-1:0] blank_value;

  delay_result_t pending_results [$];

  int fail_count  = 0;
  int cycle_count = 0;

  // Stimulus pacing knobs
  int burst_left = 0;
  int gap_max    = 0;
  int stall_pct  = 0;
  int hold_seq   = 0;
  int hold_seen  = 0;
  int hold_left  = 0;

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count++;
  endtask

  // Value k steps back; positions not pushed since restart give the blank value
  function automatic logic signed [DATA_W-1:0] line_read(int unsigned k);
    logic [ADDR_W-1:0] pos;
    pos = newest_pos - k[ADDR_W-1:0];
    if (k >= pushed_cnt || k >= STORE_DEPTH) return blank_value;
    return line_mem[pos];
  endfunction

  task automatic predict_word(act_e act, logic held, logic step,
                              logic signed [DATA_W-1:0] smp, logic [TAP_W-1:0] tap);
    logic signed [DATA_W-1:0] wr_val;
    int unsigned              eff;
    longint                   oldest_l, second_l, wgt, acc;
    delay_result_t            res;
    if (act == ACT_RESTART) begin
      newest_pos = '0;
      pushed_cnt = '0;
      return;
    end
    eff = (delay_steps > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : delay_steps;
    // update: push on a new step or when empty, else overwrite newest
    wr_val = held ? line_read(0) : smp;
    if (step || pushed_cnt == 0) begin
      newest_pos = newest_pos + 1'b1;
      if (pushed_cnt < STORE_DEPTH) pushed_cnt = pushed_cnt + 1'b1;
    end
    line_mem[newest_pos] = wr_val;
    if (act == ACT_UPDATE) return;
    res.err   = 1'b0;
    res.value = '0;
    if (act == ACT_READ_DELAY) begin
      oldest_l = line_read(eff);
      if (blend_w != 0 && eff >= 1) begin
        second_l  = line_read(eff - 1);
        wgt       = blend_w;
        acc       = second_l * (65536 - wgt) + oldest_l * wgt;
        res.value = DATA_W'(acc >>> FRAC_W);
      end else begin
        res.value = DATA_W'(oldest_l);
      end
    end else if (tap > eff) begin
      res.err = 1'b1;
    end else begin
      res.value = line_read(tap);
    end
    pending_results.push_back(res);
  endtask

  // Monitor: config writes, accepted input words, accepted results
  always @(posedge clk_i) begin
    delay_result_t want;
    if (!rst_ni) begin
      newest_pos  = '0;
      pushed_cnt  = '0;
      delay_steps = STEP_W'(1);
      blend_w     = '0;
      blank_value = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_STEP_DELAY:  delay_steps = cfg_data[STEP_W-1:0];
          CFG_FRAC_WEIGHT: blend_w     = cfg_data[FRAC_W-1:0];
          CFG_INIT_VALUE:  blank_value = cfg_data;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready)
        predict_word(act_e'(in_if.action), in_if.use_held, in_if.new_step,
                     in_if.sample, in_if.tap_index);
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%h err=%b",
                                    out_if.result_value, out_if.index_error));
        end else begin
          want = pending_results.pop_front();
          if (out_if.result_value !== want.value)
            report_mismatch($sformatf("result_value got %h want %h",
                                      out_if.result_value, want.value));
          if (out_if.index_error !== want.err)
            report_mismatch($sformatf("index_error got %b want %b",
                                      out_if.index_error, want.err));
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one word, in bursts with random gaps between them
  task automatic send_word(act_e act, logic held, logic step,
                           logic signed [DATA_W-1:0] smp, logic [TAP_W-1:0] tap);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      repeat (gap) begin
        @(negedge clk_i);
        in_if.valid     <= 1'b0;
        in_if.action    <= ACT_W'($urandom);
        in_if.sample    <= $urandom;
        in_if.tap_index <= TAP_W'($urandom);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    in_if.valid     <= 1'b1;
    in_if.action    <= act;
    in_if.use_held  <= held;
    in_if.new_step  <= step;
    in_if.sample    <= smp;
    in_if.tap_index <= tap;
    forever begin
      @(posedge clk_i);
      if (in_if.ready) break;
    end
  endtask

  task automatic write_reg(cfg_e idx, logic [DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // Wait until every result is in, then let the pipe settle
  task automatic drain_line();
    int waited;
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [STEP_W-1:0] dly, logic [FRAC_W-1:0] w,
                          logic signed [DATA_W-1:0] init);
    drain_line();
    write_reg(CFG_STEP_DELAY, DATA_W'(dly));
    write_reg(CFG_FRAC_WEIGHT, DATA_W'(w));
    write_reg(CFG_INIT_VALUE, init);
  endtask

  // Reset defaults: delay 1, no blend, blank value 0; taps, errors, held copies
  task automatic test_reset_state();
    send_word(ACT_READ_DELAY, 1'b0, 1'b1, Q_MAX, 8'd0);
    send_word(ACT_READ_DELAY, 1'b0, 1'b1, Q_MIN, 8'd0);
    send_word(ACT_READ_TAP, 1'b0, 1'b0, 32'sh1234_5678, 8'd0);
    send_word(ACT_READ_TAP, 1'b0, 1'b1, -32'sd5, 8'd1);
    send_word(ACT_READ_TAP, 1'b0, 1'b1, 32'sd9, 8'd2);
    send_word(ACT_READ_TAP, 1'b0, 1'b0, 32'sd0, 8'd255);
    send_word(ACT_UPDATE, 1'b1, 1'b1, 32'sh0BAD_0BAD, 8'd0);
    send_word(ACT_READ_DELAY, 1'b1, 1'b0, 32'sh0BAD_0BAD, 8'd0);
    send_word(ACT_RESTART, 1'b0, 1'b1, 32'sd0, 8'd0);
    // held copy right after restart writes the blank value
    send_word(ACT_READ_TAP, 1'b1, 1'b0, 32'sh5555_AAAA, 8'd0);
    send_word(ACT_READ_DELAY, 1'b0, 1'b0, 32'sh0001_0000, 8'd0);
  endtask

  // Register extremes: zero delay with full weight, maximum delay
  task automatic test_reg_extremes();
    set_regs(8'd0, 16'hFFFF, Q_MIN);
    send_word(ACT_READ_DELAY, 1'b0, 1'b1, 32'sh0003_8000, 8'd0);
    send_word(ACT_READ_TAP, 1'b0, 1'b1, -32'sh0002_0000, 8'd0);
    send_word(ACT_READ_TAP, 1'b0, 1'b0, 32'sd1, 8'd1);
    set_regs(8'd255, 16'hFFFF, Q_MAX);
    send_word(ACT_READ_DELAY, 1'b0, 1'b1, 32'sd77, 8'd0);
    send_word(ACT_READ_TAP, 1'b0, 1'b1, 32'sd78, 8'd255);
    send_word(ACT_RESTART, 1'b1, 1'b0, 32'sd0, 8'd0);
  endtask

  // Half-weight blend with negative values, then a blank-value change
  task automatic test_blend();
    set_regs(8'd2, 16'h8000, 32'sd0);
    send_word(ACT_READ_DELAY, 1'b0, 1'b1, -32'sd3, 8'd0);
    send_word(ACT_READ_DELAY, 1'b0, 1'b1, 32'sd1, 8'd0);
    send_word(ACT_READ_DELAY, 1'b0, 1'b1, Q_MIN, 8'd0);
    send_word(ACT_READ_DELAY, 1'b0, 1'b1, Q_MAX, 8'd0);
    send_word(ACT_READ_DELAY, 1'b0, 1'b1, -32'sd1, 8'd0);
    send_word(ACT_RESTART, 1'b0, 1'b0, 32'sd0, 8'd0);
    set_regs(8'd2, 16'h8000, 32'sd7);
    send_word(ACT_READ_DELAY, 1'b0, 1'b1, -32'sd8, 8'd0);
    send_word(ACT_READ_DELAY, 1'b0, 1'b1, 32'sd100, 8'd0);
  endtask

  // Receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    set_regs(8'd1, 16'h4000, -32'sd2);
    gap_max   = 0;
    stall_pct = 0;
    hold_seq++;
    repeat (40)
      send_word(($urandom_range(0, 1) != 0) ? ACT_READ_DELAY : ACT_READ_TAP,
                1'b0, 1'b1, $urandom, TAP_W'($urandom_range(0, 2)));
  endtask

  task automatic run_random_phase(logic [STEP_W-1:0] dly, logic [FRAC_W-1:0] w,
                                  logic signed [DATA_W-1:0] init, int count,
                                  int gap, int stall, int restart_pct);
    int                       r;
    act_e                     act;
    logic signed [DATA_W-1:0] smp;
    logic [TAP_W-1:0]         tap;
    int                       tap_hi;
    set_regs(dly, w, init);
    gap_max   = gap;
    stall_pct = stall;
    tap_hi    = (dly >= 254) ? 255 : dly + 1;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < restart_pct)      act = ACT_RESTART;
      else if (r < 12)          act = ACT_UPDATE;
      else if (r < 56)          act = ACT_READ_DELAY;
      else                      act = ACT_READ_TAP;
      case ($urandom_range(0, 19))
        0:       smp = Q_MAX;
        1:       smp = Q_MIN;
        2:       smp = -32'sd1;
        default: smp = $urandom;
      endcase
      tap = ($urandom_range(0, 4) == 0) ? TAP_W'($urandom)
                                         : TAP_W'($urandom_range(0, tap_hi));
      send_word(act, $urandom_range(0, 4) == 0, $urandom_range(0, 3) != 0, smp, tap);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_STEP_DELAY;
    cfg_data        = '0;
    in_if.valid     = 1'b0;
    in_if.action    = ACT_UPDATE;
    in_if.use_held  = 1'b0;
    in_if.new_step  = 1'b0;
    in_if.sample    = '0;
    in_if.tap_index = '0;
    out_if.ready    = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    gap_max   = 3;
    stall_pct = 25;
    test_reset_state();
    test_reg_extremes();
    test_blend();
    test_backpressure();

    run_random_phase(8'd1, 16'd0, 32'sd0, 200, 0, 0, 3);
    run_random_phase(8'd0, 16'hFFFF, Q_MIN, 200, 6, 30, 3);
    run_random_phase(8'd255, 16'hFFFF, Q_MAX, 400, 3, 50, 0);
    run_random_phase(8'd3, 16'h8000, $urandom, 250, 8, 20, 3);
    run_random_phase(STEP_W'($urandom_range(0, 20)), FRAC_W'($urandom), $urandom,
                     250, 4, 70, 3);
    run_random_phase(8'd2, 16'd1, -32'sd1, 200, 2, 10, 2);

    drain_line();
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
